FILE: hdl/levus_pkg.sv
// ----------------------------------------------------------------------------
// levus_pkg
// shared types and constants for the little-endian / varint byte serializer
// ----------------------------------------------------------------------------
package levus_pkg;

   localparam int VALUE_W     = 64;
   localparam int CMD_W       = 3;
   localparam int BYTE_W      = 8;
   localparam int OFFSET_W    = 11;
   localparam int LEFT_W      = 4;
   localparam int GROUP_W     = 7;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [CMD_W-1:0] {
      CMD_BYTE   = 3'd0,
      CMD_WORD16 = 3'd1,
      CMD_WORD32 = 3'd2,
      CMD_WORD64 = 3'd3,
      CMD_VARINT = 3'd4
   } cmd_type;

endpackage

FILE: hdl/le_varuint_byte_serializer_core.sv
// ----------------------------------------------------------------------------
// le_varuint_byte_serializer_core
// serializes one 64-bit value per word as a byte, a 16/32/64-bit
// little-endian word or an unsigned LEB128 varint; while the output is not stalled, one byte per cycle
// ----------------------------------------------------------------------------
// The value is loaded into a 64-bit shift register and leaves it one byte per
// cycle while the output is not stalled, least significant group first: 1, 2,
// 4 or 8 bytes for the fixed widths and 1 to 10 bytes for a varint (7 bits per
// byte). The shift register holds one value at a time, so the next request
// word is taken in the cycle after the last byte of the current one moves into
// the output register; a word with an unused command is taken and dropped.
// Each byte carries its offset, a running count that saturates at
// BUFFER_BYTES; bytes at or past that point are flagged as overflow.
module le_varuint_byte_serializer_core
   import levus_pkg::*;
#(
   parameter int BUFFER_BYTES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // value[63:0]
   input  logic [CMD_W-1:0]       req_tuser,   // command[2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // out_byte[7:0], offset[18:8], zero[23:19]
   output logic                   rsp_tlast,   // last
   output logic                   rsp_tuser    // overflow
);

   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam logic [CW-1:0] BUF_LIMIT = CW'(BUFFER_BYTES);

   logic                busy_ff, busy_in;
   logic                varint_ff, varint_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [VALUE_W-1:0]  shift_ff, shift_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                last_ff, last_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                ovf_ff, ovf_in;

   logic                accept;
   logic                advance;
   logic                rest_zero;
   logic [BYTE_W-1:0]   cur_byte;
   logic                cur_last;
   logic                cur_ovf;
   logic [CW-1:0]       cur_pos;
   logic [CW+OFFSET_W-1:0] pos_ext;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign advance    = busy_ff && (!rsp_valid_ff || rsp_tready);

   assign rest_zero = (shift_ff[VALUE_W-1:GROUP_W] == '0);
   assign cur_byte  = varint_ff ? {!rest_zero, shift_ff[GROUP_W-1:0]} : shift_ff[BYTE_W-1:0];
   assign cur_last  = varint_ff ? rest_zero : (left_ff == LEFT_W'(1));
   assign cur_ovf   = (count_ff >= BUF_LIMIT);
   assign cur_pos   = cur_ovf ? BUF_LIMIT : count_ff;
   assign pos_ext   = {{OFFSET_W{1'b0}}, cur_pos};

   always_comb begin
      busy_in      = busy_ff;
      varint_in    = varint_ff;
      left_in      = left_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      offset_in    = offset_ff;
      ovf_in       = ovf_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         shift_in  = req_tdata;
         varint_in = 1'b0;
         busy_in   = 1'b1;
         case (cmd_type'(req_tuser))
            CMD_BYTE:   left_in = LEFT_W'(1);
            CMD_WORD16: left_in = LEFT_W'(2);
            CMD_WORD32: left_in = LEFT_W'(4);
            CMD_WORD64: left_in = LEFT_W'(8);
            CMD_VARINT: begin
               varint_in = 1'b1;
               left_in   = '0;
            end
            default: busy_in = 1'b0;
         endcase
      end else if (advance) begin
         shift_in     = varint_ff ? (shift_ff >> GROUP_W) : (shift_ff >> BYTE_W);
         left_in      = left_ff - LEFT_W'(1);
         busy_in      = !cur_last;
         rsp_valid_in = 1'b1;
         byte_in      = cur_byte;
         last_in      = cur_last;
         offset_in    = pos_ext[OFFSET_W-1:0];
         ovf_in       = cur_ovf;
         if (!cur_ovf) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      varint_ff <= varint_in;
      left_ff   <= left_in;
      shift_ff  <= shift_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      offset_ff <= offset_in;
      ovf_ff    <= ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-OFFSET_W-BYTE_W){1'b0}}, offset_ff, byte_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = ovf_ff;

endmodule

FILE: hdl/levus_checker.sv
// ----------------------------------------------------------------------------
// levus_checker
// port-level checks for the byte serializer core
// ----------------------------------------------------------------------------
module levus_checker
   import levus_pkg::*;
#(
   parameter int BUFFER_BYTES = 1024
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [CMD_W-1:0]       req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   rsp_tuser
);

   localparam logic [OFFSET_W-1:0] LIMIT_OFS = OFFSET_W'(BUFFER_BYTES);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // overflow bytes report the saturated offset
   a_ovf_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[18:8] == LIMIT_OFS)
      else $error("overflow byte with unsaturated offset");

   // in-range bytes lie below the buffer size
   a_inrange_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (BUFFER_BYTES > 2047) || (rsp_tdata[18:8] < LIMIT_OFS))
      else $error("in-range byte offset past buffer size");

   // a valid command leaves the serializer busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser <= CMD_VARINT) |=> !req_tready)
      else $error("request taken while serializing");

   // reset leaves the block empty and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind le_varuint_byte_serializer_core levus_checker #(
   .BUFFER_BYTES(BUFFER_BYTES)
) u_levus_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
